@@ hdl/ipv4_receive_header_filter_defines.svh @@
// Assertion macros shared by the IPv4 receive header filter checker.
`ifndef IPV4_RECEIVE_HEADER_FILTER_DEFINES_SVH
`define IPV4_RECEIVE_HEADER_FILTER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define IPV4RX_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define IPV4RX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/ipv4rx_pkg.sv @@
// Types, constants and helper functions of the IPv4 receive header filter.
package ipv4rx_pkg;

    localparam int HEADER_WORDS = 10;
    localparam int IDX_W        = $clog2(HEADER_WORDS);
    localparam int WORD_W       = 16;
    localparam int ADDR_W       = 32;
    localparam int CNT_W        = 32;
    localparam int BYTE_W       = 8;

    localparam logic [IDX_W-1:0] POS_VERSION  = IDX_W'(0);
    localparam logic [IDX_W-1:0] POS_PROTOCOL = IDX_W'(4);
    localparam logic [IDX_W-1:0] POS_DEST_HI  = IDX_W'(8);
    localparam logic [IDX_W-1:0] POS_LAST     = IDX_W'(HEADER_WORDS - 1);

    localparam logic [BYTE_W-1:0] VERSION_LENGTH_OK = 8'h45;
    localparam logic [BYTE_W-1:0] PROTO_ICMP        = 8'd1;
    localparam logic [BYTE_W-1:0] PROTO_TCP         = 8'd6;
    localparam logic [BYTE_W-1:0] PROTO_UDP         = 8'd17;
    localparam logic [WORD_W-1:0] SUM_GOOD          = 16'hFFFF;

    typedef enum logic [2:0] {
        VERDICT_ICMP     = 3'd0,
        VERDICT_TCP      = 3'd1,
        VERDICT_UDP      = 3'd2,
        VERDICT_ADDR     = 3'd3,
        VERDICT_UNKNOWN  = 3'd4,
        VERDICT_CHECKSUM = 3'd5
    } t_verdict;

    // Summary of the header being completed, handed from accumulator to judge.
    typedef struct packed {
        logic              done;
        logic              sum_ok;
        logic [BYTE_W-1:0] version_length;
        logic [BYTE_W-1:0] protocol;
        logic [ADDR_W-1:0] destination;
    } t_hdr_status;

    // Ones'-complement addition with end-around carry.
    function automatic logic [WORD_W-1:0] ones_add(input logic [WORD_W-1:0] a,
                                                   input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
    endfunction

endpackage

@@ hdl/ipv4_receive_header_filter.sv @@
// The tenth word of a header passes the input register and then the result register.
// Throughput: one header word per cycle while the input is not stalled; the accumulator
// and the judge each produce their part combinationally between the input and result registers.
// The input stalls only while a result is held under output stall.
// Reset (synchronous, active low) clears the address register, the word
// position, the result valid and all four statistics counters.
module ipv4_receive_header_filter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_my_address_wr_en,
    input  logic [ipv4rx_pkg::ADDR_W-1:0]       i_my_address,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [ipv4rx_pkg::WORD_W-1:0]       i_header_word,
    input  logic                                i_first_word,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [2:0]                          o_verdict,
    output logic [ipv4rx_pkg::BYTE_W-1:0]       o_protocol,
    output logic [ipv4rx_pkg::CNT_W-1:0]        o_received_count,
    output logic [ipv4rx_pkg::CNT_W-1:0]        o_address_error_count,
    output logic [ipv4rx_pkg::CNT_W-1:0]        o_unknown_proto_count,
    output logic [ipv4rx_pkg::CNT_W-1:0]        o_header_error_count
);

    logic                          r_in_valid;
    logic [ipv4rx_pkg::WORD_W-1:0] r_in_word;
    logic                          r_in_first;
    logic [ipv4rx_pkg::ADDR_W-1:0] r_my_address;

    logic                          out_free;
    logic                          advance;
    ipv4rx_pkg::t_hdr_status       hdr_status;

    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_my_address <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (i_my_address_wr_en) begin
                r_my_address <= i_my_address;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_word  <= i_header_word;
            r_in_first <= i_first_word;
        end
    end

    ipv4rx_accum u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_word    (r_in_word),
        .i_first   (r_in_first),
        .o_status  (hdr_status)
    );

    ipv4rx_judge u_judge (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_status              (hdr_status),
        .i_my_address          (r_my_address),
        .i_out_stall           (i_out_stall),
        .o_out_free            (out_free),
        .o_out_valid           (o_out_valid),
        .o_verdict             (o_verdict),
        .o_protocol            (o_protocol),
        .o_received_count      (o_received_count),
        .o_address_error_count (o_address_error_count),
        .o_unknown_proto_count (o_unknown_proto_count),
        .o_header_error_count  (o_header_error_count)
    );

endmodule

@@ hdl/ipv4rx_accum.sv @@
// Word accumulator: running checksum, word position and captured header fields.
module ipv4rx_accum (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_advance,
    input  logic [ipv4rx_pkg::WORD_W-1:0]       i_word,
    input  logic                                i_first,
    output ipv4rx_pkg::t_hdr_status             o_status
);

    logic [ipv4rx_pkg::IDX_W-1:0]  r_index;
    logic [ipv4rx_pkg::WORD_W-1:0] r_sum;
    logic [ipv4rx_pkg::BYTE_W-1:0] r_version;
    logic [ipv4rx_pkg::BYTE_W-1:0] r_protocol;
    logic [ipv4rx_pkg::WORD_W-1:0] r_dest_hi;

    logic [ipv4rx_pkg::IDX_W-1:0]  n_index;
    logic [ipv4rx_pkg::WORD_W-1:0] n_sum;
    logic [ipv4rx_pkg::BYTE_W-1:0] n_version;
    logic [ipv4rx_pkg::BYTE_W-1:0] n_protocol;

    logic                          take;
    logic                          last;
    logic [ipv4rx_pkg::IDX_W-1:0]  pos;
    logic [ipv4rx_pkg::WORD_W-1:0] base;

    // A word without a start flag is dropped when no header is in progress.
    assign take = i_advance && (i_first || (r_index != ipv4rx_pkg::POS_VERSION));
    assign pos  = i_first ? ipv4rx_pkg::POS_VERSION : r_index;
    assign base = i_first ? '0 : r_sum;
    assign last = (pos == ipv4rx_pkg::POS_LAST);

    assign n_sum      = ipv4rx_pkg::ones_add(base, i_word);
    assign n_version  = (pos == ipv4rx_pkg::POS_VERSION)
                        ? i_word[ipv4rx_pkg::WORD_W-1:ipv4rx_pkg::BYTE_W] : r_version;
    assign n_protocol = (pos == ipv4rx_pkg::POS_PROTOCOL)
                        ? i_word[ipv4rx_pkg::BYTE_W-1:0] : r_protocol;
    assign n_index    = last ? ipv4rx_pkg::POS_VERSION : pos + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
        end else if (take) begin
            r_index <= n_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_sum      <= n_sum;
            r_version  <= n_version;
            r_protocol <= n_protocol;
            if (pos == ipv4rx_pkg::POS_DEST_HI) begin
                r_dest_hi <= i_word;
            end
        end
    end

    // The last word carries the low half of the destination address.
    always_comb begin
        o_status.done           = take && last;
        o_status.sum_ok         = (n_sum == ipv4rx_pkg::SUM_GOOD);
        o_status.version_length = n_version;
        o_status.protocol       = n_protocol;
        o_status.destination    = {r_dest_hi, i_word};
    end

endmodule

@@ hdl/ipv4rx_judge.sv @@
// Verdict logic, statistics counters and the result register.
module ipv4rx_judge (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ipv4rx_pkg::t_hdr_status             i_status,
    input  logic [ipv4rx_pkg::ADDR_W-1:0]       i_my_address,
    input  logic                                i_out_stall,
    output logic                                o_out_free,
    output logic                                o_out_valid,
    output logic [2:0]                          o_verdict,
    output logic [ipv4rx_pkg::BYTE_W-1:0]       o_protocol,
    output logic [ipv4rx_pkg::CNT_W-1:0]        o_received_count,
    output logic [ipv4rx_pkg::CNT_W-1:0]        o_address_error_count,
    output logic [ipv4rx_pkg::CNT_W-1:0]        o_unknown_proto_count,
    output logic [ipv4rx_pkg::CNT_W-1:0]        o_header_error_count
);

    logic                          r_out_valid;
    ipv4rx_pkg::t_verdict          r_verdict;
    logic [ipv4rx_pkg::BYTE_W-1:0] r_protocol;
    logic [ipv4rx_pkg::CNT_W-1:0]  r_total;
    logic [ipv4rx_pkg::CNT_W-1:0]  r_addr_err;
    logic [ipv4rx_pkg::CNT_W-1:0]  r_unknown;
    logic [ipv4rx_pkg::CNT_W-1:0]  r_sum_err;

    ipv4rx_pkg::t_verdict          n_verdict;

    always_comb begin
        if (i_status.destination != i_my_address) begin
            n_verdict = ipv4rx_pkg::VERDICT_ADDR;
        end else if (i_status.version_length != ipv4rx_pkg::VERSION_LENGTH_OK) begin
            n_verdict = ipv4rx_pkg::VERDICT_UNKNOWN;
        end else if (!i_status.sum_ok) begin
            n_verdict = ipv4rx_pkg::VERDICT_CHECKSUM;
        end else if (i_status.protocol == ipv4rx_pkg::PROTO_ICMP) begin
            n_verdict = ipv4rx_pkg::VERDICT_ICMP;
        end else if (i_status.protocol == ipv4rx_pkg::PROTO_TCP) begin
            n_verdict = ipv4rx_pkg::VERDICT_TCP;
        end else if (i_status.protocol == ipv4rx_pkg::PROTO_UDP) begin
            n_verdict = ipv4rx_pkg::VERDICT_UDP;
        end else begin
            n_verdict = ipv4rx_pkg::VERDICT_UNKNOWN;
        end
    end

    assign o_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_total     <= '0;
            r_addr_err  <= '0;
            r_unknown   <= '0;
            r_sum_err   <= '0;
        end else if (i_status.done) begin
            r_out_valid <= 1'b1;
            r_total     <= r_total + 1'b1;
            case (n_verdict)
                ipv4rx_pkg::VERDICT_ADDR:     r_addr_err <= r_addr_err + 1'b1;
                ipv4rx_pkg::VERDICT_UNKNOWN:  r_unknown  <= r_unknown + 1'b1;
                ipv4rx_pkg::VERDICT_CHECKSUM: r_sum_err  <= r_sum_err + 1'b1;
                default: ;
            endcase
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_status.done) begin
            r_verdict  <= n_verdict;
            r_protocol <= i_status.protocol;
        end
    end

    // Counters only move when a new result is loaded, so they double as its fields.
    assign o_out_valid           = r_out_valid;
    assign o_verdict             = r_verdict;
    assign o_protocol            = r_protocol;
    assign o_received_count      = r_total;
    assign o_address_error_count = r_addr_err;
    assign o_unknown_proto_count = r_unknown;
    assign o_header_error_count  = r_sum_err;

endmodule

@@ hdl/ipv4rx_checker.sv @@
// Port-level checker for the IPv4 receive header filter, bound to the top level.
`include "ipv4_receive_header_filter_defines.svh"

module ipv4rx_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic [2:0]                          o_verdict,
    input logic [ipv4rx_pkg::BYTE_W-1:0]       o_protocol,
    input logic [ipv4rx_pkg::CNT_W-1:0]        o_received_count,
    input logic [ipv4rx_pkg::CNT_W-1:0]        o_address_error_count
);

    `IPV4RX_ASSERT_NEXT(a_result_held, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_verdict) && $stable(o_protocol),
        "stalled result changed")

    `IPV4RX_ASSERT_SAME(a_count_with_result,
        $past(i_rst_n) && !$stable(o_received_count), o_out_valid,
        "received count moved without a result")

    `IPV4RX_ASSERT_SAME(a_count_step,
        $past(i_rst_n) && !$stable(o_received_count),
        o_received_count == $past(o_received_count) + 32'd1,
        "received count did not step by one")

    `IPV4RX_ASSERT_SAME(a_addr_error_count,
        $past(i_rst_n) && !$stable(o_received_count) &&
        (o_verdict == ipv4rx_pkg::VERDICT_ADDR),
        o_address_error_count == $past(o_address_error_count) + 32'd1,
        "address error verdict without its counter step")

endmodule

bind ipv4_receive_header_filter ipv4rx_checker u_ipv4rx_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .o_out_valid           (o_out_valid),
    .i_out_stall           (i_out_stall),
    .o_verdict             (o_verdict),
    .o_protocol            (o_protocol),
    .o_received_count      (o_received_count),
    .o_address_error_count (o_address_error_count)
);

@@ tb/tb_ipv4_receive_header_filter.sv @@
// Self-checking testbench of the IPv4 receive header filter with its own header predictor.
module tb_ipv4_receive_header_filter;
    import ipv4rx_pkg::*;

    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 6;

    typedef logic [HEADER_WORDS-1:0][WORD_W-1:0] t_header_words;

    typedef struct {
        t_verdict          verdict;
        logic [BYTE_W-1:0] protocol;
        logic [CNT_W-1:0]  received;
        logic [CNT_W-1:0]  address_errors;
        logic [CNT_W-1:0]  unknown_protos;
        logic [CNT_W-1:0]  checksum_errors;
    } t_header_outcome;

    logic               i_clk              = 1'b0;
    logic               i_rst_n            = 1'b0;
    logic               i_my_address_wr_en = 1'b0;
    logic [ADDR_W-1:0]  i_my_address       = '0;
    logic               i_in_valid         = 1'b0;
    logic [WORD_W-1:0]  i_header_word      = '0;
    logic               i_first_word       = 1'b0;
    logic               i_out_stall        = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [2:0]         o_verdict;
    logic [BYTE_W-1:0]  o_protocol;
    logic [CNT_W-1:0]   o_received_count;
    logic [CNT_W-1:0]   o_address_error_count;
    logic [CNT_W-1:0]   o_unknown_proto_count;
    logic [CNT_W-1:0]   o_header_error_count;

    // Predictor state.
    logic [ADDR_W-1:0]  station_address = '0;
    logic [IDX_W-1:0]   word_pos        = '0;
    logic [WORD_W-1:0]  running_sum     = '0;
    logic [BYTE_W-1:0]  cap_version     = '0;
    logic [BYTE_W-1:0]  cap_protocol    = '0;
    logic [ADDR_W-1:0]  cap_destination = '0;
    logic [CNT_W-1:0]   exp_received    = '0;
    logic [CNT_W-1:0]   exp_addr_err    = '0;
    logic [CNT_W-1:0]   exp_unknown     = '0;
    logic [CNT_W-1:0]   exp_checksum    = '0;

    t_header_outcome    expected_outcomes[$];
    int                 mismatch_count = 0;

    bit                 steady      = 1'b0;
    int unsigned        hold_ticket = 0;
    int unsigned        hold_served = 0;
    int unsigned        hold_left   = 0;

    ipv4_receive_header_filter u_top (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_my_address_wr_en    (i_my_address_wr_en),
        .i_my_address          (i_my_address),
        .i_in_valid            (i_in_valid),
        .o_in_stall            (o_in_stall),
        .i_header_word         (i_header_word),
        .i_first_word          (i_first_word),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_verdict             (o_verdict),
        .o_protocol            (o_protocol),
        .o_received_count      (o_received_count),
        .o_address_error_count (o_address_error_count),
        .o_unknown_proto_count (o_unknown_proto_count),
        .o_header_error_count  (o_header_error_count)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #200000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [WORD_W-1:0] fold_add(input logic [WORD_W-1:0] a,
                                                   input logic [WORD_W-1:0] b);
        logic [WORD_W:0] total;
        total = {1'b0, a} + {1'b0, b};
        return total[WORD_W-1:0] + WORD_W'(total[WORD_W]);
    endfunction

    // Advances the predicted header state by one word; returns 1 when a verdict is due.
    function automatic bit absorb_word(input logic [WORD_W-1:0] word, input bit first,
                                       output t_header_outcome outcome);
        logic [IDX_W-1:0] pos;
        t_verdict         verdict;
        if (first) begin
            pos = '0;
            running_sum = '0;
        end else if (word_pos == '0) begin
            return 1'b0;
        end else begin
            pos = word_pos;
        end
        running_sum = fold_add(running_sum, word);
        case (pos)
            POS_VERSION:  cap_version = word[15:8];
            POS_PROTOCOL: cap_protocol = word[7:0];
            POS_DEST_HI:  cap_destination[31:16] = word;
            POS_LAST:     cap_destination[15:0] = word;
            default: ;
        endcase
        if (pos != POS_LAST) begin
            word_pos = pos + 1'b1;
            return 1'b0;
        end
        word_pos = '0;
        exp_received = exp_received + 1'b1;
        if (cap_destination != station_address) begin
            exp_addr_err = exp_addr_err + 1'b1;
            verdict = VERDICT_ADDR;
        end else if (cap_version != VERSION_LENGTH_OK) begin
            exp_unknown = exp_unknown + 1'b1;
            verdict = VERDICT_UNKNOWN;
        end else if (running_sum != SUM_GOOD) begin
            exp_checksum = exp_checksum + 1'b1;
            verdict = VERDICT_CHECKSUM;
        end else if (cap_protocol == PROTO_ICMP) begin
            verdict = VERDICT_ICMP;
        end else if (cap_protocol == PROTO_TCP) begin
            verdict = VERDICT_TCP;
        end else if (cap_protocol == PROTO_UDP) begin
            verdict = VERDICT_UDP;
        end else begin
            exp_unknown = exp_unknown + 1'b1;
            verdict = VERDICT_UNKNOWN;
        end
        outcome.verdict         = verdict;
        outcome.protocol        = cap_protocol;
        outcome.received        = exp_received;
        outcome.address_errors  = exp_addr_err;
        outcome.unknown_protos  = exp_unknown;
        outcome.checksum_errors = exp_checksum;
        return 1'b1;
    endfunction

    // Builds a header with random filler; the checksum word makes the sum come out
    // to all ones unless a bad checksum is asked for.
    function automatic t_header_words make_header(input logic [ADDR_W-1:0] dest,
                                                  input logic [BYTE_W-1:0] version_length,
                                                  input logic [BYTE_W-1:0] protocol,
                                                  input bit good_sum);
        t_header_words     hdr;
        logic [WORD_W-1:0] partial;
        for (int i = 0; i < HEADER_WORDS; i++)
            hdr[i] = WORD_W'($urandom);
        hdr[0] = {version_length, 8'($urandom)};
        hdr[4] = {8'($urandom), protocol};
        hdr[8] = dest[31:16];
        hdr[9] = dest[15:0];
        partial = '0;
        for (int i = 0; i < HEADER_WORDS; i++)
            if (i != 5)
                partial = fold_add(partial, hdr[i]);
        hdr[5] = ~partial;
        if (!good_sum)
            hdr[5] = hdr[5] + 1'b1;
        return hdr;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("t=%0t mismatch: %s", $time, what);
    endtask

    task automatic send_word(input logic [WORD_W-1:0] word, input bit first);
        t_header_outcome outcome;
        while (!steady && $urandom_range(99) < 7) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_header_word <= word;
        i_first_word  <= first;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        if (absorb_word(word, first, outcome))
            expected_outcomes.push_back(outcome);
    endtask

    task automatic send_header(input t_header_words hdr, input int words);
        for (int i = 0; i < words; i++)
            send_word(hdr[i], i == 0);
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (expected_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_address(input logic [ADDR_W-1:0] addr);
        i_my_address_wr_en <= 1'b1;
        i_my_address       <= addr;
        @(posedge i_clk);
        i_my_address_wr_en <= 1'b0;
        station_address = addr;
    endtask

    task automatic send_random_header();
        logic [ADDR_W-1:0] dest;
        logic [BYTE_W-1:0] version_length;
        logic [BYTE_W-1:0] protocol;
        case ($urandom_range(9))
            0:       dest = $urandom;
            1:       dest = station_address ^ (32'h1 << $urandom_range(31));
            default: dest = station_address;
        endcase
        version_length = ($urandom_range(99) < 88) ? VERSION_LENGTH_OK : 8'($urandom);
        case ($urandom_range(3))
            0:       protocol = PROTO_ICMP;
            1:       protocol = PROTO_TCP;
            2:       protocol = PROTO_UDP;
            default: protocol = 8'($urandom);
        endcase
        send_header(make_header(dest, version_length, protocol, $urandom_range(99) < 85),
                    HEADER_WORDS);
    endtask

    task automatic test_reset_address();
        t_header_words hdr;
        // The address register is still zero from reset here.
        hdr = '0;
        send_header(hdr, HEADER_WORDS);
        send_header(make_header('0, VERSION_LENGTH_OK, PROTO_ICMP, 1'b1), HEADER_WORDS);
        wait_for_results();
    endtask

    task automatic test_each_verdict();
        t_header_words hdr;
        write_address('1);
        send_header(make_header('1, VERSION_LENGTH_OK, PROTO_TCP, 1'b1), HEADER_WORDS);
        send_header(make_header('1, VERSION_LENGTH_OK, PROTO_UDP, 1'b1), HEADER_WORDS);
        send_header(make_header('1, VERSION_LENGTH_OK, PROTO_ICMP, 1'b1), HEADER_WORDS);
        send_header(make_header(32'hFFFF_FFFE, VERSION_LENGTH_OK, PROTO_TCP, 1'b1),
                    HEADER_WORDS);
        send_header(make_header('1, 8'h46, PROTO_UDP, 1'b1), HEADER_WORDS);
        send_header(make_header('1, VERSION_LENGTH_OK, 8'hFF, 1'b1), HEADER_WORDS);
        send_header(make_header('1, VERSION_LENGTH_OK, PROTO_ICMP, 1'b0), HEADER_WORDS);
        hdr = '1;
        send_header(hdr, HEADER_WORDS);
        wait_for_results();
    endtask

    task automatic test_framing();
        t_header_words hdr;
        // A word without the start flag while idle must be dropped.
        send_word(16'hFFFF, 1'b0);
        send_word(16'h0000, 1'b0);
        // Partial headers abandoned by a new start flag.
        hdr = make_header('1, VERSION_LENGTH_OK, PROTO_TCP, 1'b1);
        send_header(hdr, 4);
        send_header(hdr, HEADER_WORDS - 1);
        send_header(hdr, HEADER_WORDS);
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        logic [ADDR_W-1:0] settings[4];
        t_header_words     hdr;
        settings[0] = '0;
        settings[1] = $urandom;
        settings[2] = '1;
        settings[3] = $urandom;
        foreach (settings[p]) begin
            write_address(settings[p]);
            for (int n = 0; n < 15; n++) begin
                case ($urandom_range(99)) inside
                    [0:79]:  send_random_header();
                    [80:89]: begin
                        // A cut-off header; the next start flag drops it unless stray words finish it first.
                        hdr = make_header(station_address, VERSION_LENGTH_OK, PROTO_UDP, 1'b1);
                        send_header(hdr, $urandom_range(1, HEADER_WORDS - 1));
                    end
                    default: begin
                        repeat ($urandom_range(1, 3))
                            send_word(WORD_W'($urandom), 1'b0);
                    end
                endcase
            end
            wait_for_results();
        end
    endtask

    task automatic test_output_hold_off();
        hold_ticket <= hold_ticket + 1;
        // The sender keeps offering words while the stalled output holds a result and stalls the input.
        repeat (6) send_random_header();
        wait_for_results();
    endtask

    task automatic test_back_to_back();
        steady <= 1'b1;
        @(posedge i_clk);
        repeat (8) send_random_header();
        wait_for_results();
        steady <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (hold_ticket != hold_served) begin
            hold_served <= hold_ticket;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !steady && ($urandom_range(99) < 7);
        end
    end

    always @(posedge i_clk) begin : check_result
        t_header_outcome want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_outcomes.size() == 0) begin
                report_mismatch("result with no header pending");
            end else begin
                want = expected_outcomes.pop_front();
                if (o_verdict !== want.verdict)
                    report_mismatch($sformatf("verdict %0d, expected %0d",
                                              o_verdict, want.verdict));
                if (o_protocol !== want.protocol)
                    report_mismatch($sformatf("protocol %0d, expected %0d",
                                              o_protocol, want.protocol));
                if (o_received_count !== want.received)
                    report_mismatch($sformatf("received count %0d, expected %0d",
                                              o_received_count, want.received));
                if (o_address_error_count !== want.address_errors)
                    report_mismatch($sformatf("address error count %0d, expected %0d",
                                              o_address_error_count, want.address_errors));
                if (o_unknown_proto_count !== want.unknown_protos)
                    report_mismatch($sformatf("unknown protocol count %0d, expected %0d",
                                              o_unknown_proto_count, want.unknown_protos));
                if (o_header_error_count !== want.checksum_errors)
                    report_mismatch($sformatf("checksum error count %0d, expected %0d",
                                              o_header_error_count, want.checksum_errors));
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_address();
        test_each_verdict();
        test_framing();
        test_random_traffic();
        test_output_hold_off();
        test_back_to_back();
        wait_for_results();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/ipv4rx_pkg.sv
hdl/ipv4rx_accum.sv
hdl/ipv4rx_judge.sv
hdl/ipv4_receive_header_filter.sv
hdl/ipv4rx_checker.sv
tb/tb_ipv4_receive_header_filter.sv
